>>> hdl/assert_macros.svh
// assertion macros used by the checker file of the frame receiver
// clocked property with and without a reset qualifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge once reset is released
`define CFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfr_checker: property violated");

// property checked on every rising edge, reset included
`define CFR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cfr_checker: reset property violated");

`endif

>>> hdl/cfr_pkg.sv
// shared types, constants and crc function of the crc8 frame receiver
// no dependencies
`default_nettype none

package cfr_pkg;

    // framing constants
    localparam logic [7:0] SYNC_A          = 8'hA5;
    localparam logic [7:0] SYNC_B          = 8'h5A;
    localparam logic [7:0] KIND_IMU        = 8'h01;
    localparam logic [7:0] KIND_LAST_PLAIN = 8'h07;
    localparam logic [7:0] KIND_CONTROL    = 8'h10;
    localparam logic [2:0] CONTROL_SLOT    = 3'd7;
    localparam logic [7:0] CONTROL_VERSION = 8'h01;
    localparam int         CONTROL_MIN_LEN = 8;
    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd100;
    localparam logic [7:0] MAX_DIVISOR     = 8'd8;
    localparam logic [7:0] MAX_PAYLOAD     = 8'd64;
    localparam logic [7:0] CRC_POLY        = 8'hD5;
    localparam logic [31:0] LATE_GAP_RESET = 32'd5000;

    // widths
    localparam int LEN_W       = 7;
    localparam int NUM_SLOTS   = 8;
    localparam int HEAD_BYTES  = 8;
    localparam int HEAD_IDX_W  = $clog2(HEAD_BYTES);
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 120;
    localparam int M_TUSER_W   = 8;

    // frame status codes
    localparam logic [1:0] STATUS_DELIVERED = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN   = 2'd2;
    localparam logic [1:0] STATUS_BAD_CTRL  = 2'd3;

    // imu gap codes
    localparam logic [1:0] GAP_NONE = 2'd0;
    localparam logic [1:0] GAP_OK   = 2'd1;
    localparam logic [1:0] GAP_LATE = 2'd2;

    typedef enum logic [2:0] {
        PH_SYNC_A = 3'd0,
        PH_SYNC_B = 3'd1,
        PH_TYPE   = 3'd2,
        PH_SEQ    = 3'd3,
        PH_LEN    = 3'd4,
        PH_BODY   = 3'd5,
        PH_CHECK  = 3'd6
    } parse_phase_t;

    // one received byte with its arrival time
    typedef struct packed {
        logic [31:0] now_us;
        logic [7:0]  rx_byte;
    } in_item_t;

    // completed frame handed from parser to tracker
    typedef struct packed {
        logic                           fire;
        logic                           crc_ok;
        logic [7:0]                     kind;
        logic [7:0]                     seq;
        logic [LEN_W-1:0]               length;
        logic [HEAD_BYTES-1:0][7:0]     head;
        logic [31:0]                    now_us;
    } frame_evt_t;

    // one result item
    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  frame_kind;
        logic [7:0]  frame_number;
        logic [7:0]  lost_frames;
        logic [31:0] imu_gap_us;
        logic [1:0]  imu_gap_kind;
        logic        stream_enabled;
        logic [7:0]  session_number;
        logic [15:0] control_flags;
        logic [15:0] imu_rate_hz;
        logic [3:0]  return_divisor;
        logic [15:0] timeout_ms;
    } result_t;

    // crc-8/dvb-s2 update by one byte, msb first
    function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/cfr_input_stage.sv
// input register of the frame receiver, holds one byte transfer
// depends on cfr_pkg
`default_nettype none

module cfr_input_stage (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [cfr_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                     take,
    output logic                          item_valid,
    output cfr_pkg::in_item_t             item
);
    import cfr_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // free when empty or when the held byte is consumed this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.rx_byte <= s_tdata[7:0];
            item_reg.now_us  <= s_tdata[39:8];
        end
    end

endmodule

`default_nettype wire

>>> hdl/cfr_frame_parser.sv
// sync hunt, header capture, payload head store and running crc
// depends on cfr_pkg
`default_nettype none

module cfr_frame_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire cfr_pkg::in_item_t item,
    input  wire logic              out_busy,
    output logic                   take,
    output cfr_pkg::frame_evt_t    evt
);
    import cfr_pkg::*;

    parse_phase_t              phase_reg, phase_next;
    logic [7:0]                type_reg, type_next;
    logic [7:0]                seq_reg, seq_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [LEN_W-1:0]          fill_reg, fill_next;
    logic [LEN_W-1:0]          fill_inc;
    logic [7:0]                crc_reg, crc_next;
    logic [HEAD_BYTES-1:0][7:0] head_reg;
    logic                      head_we;
    logic                      evt_fire;
    logic                      evt_crc_ok;
    logic [7:0]                b;

    assign b        = item.rx_byte;
    assign fill_inc = fill_reg + 1'b1;

    // hold a crc byte while the result register is still occupied
    assign take = item_valid && !((phase_reg == PH_CHECK) && out_busy);

    // next state of the parser
    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        crc_next   = crc_reg;
        head_we    = 1'b0;
        evt_fire   = 1'b0;
        evt_crc_ok = 1'b0;
        if (take) begin
            case (phase_reg)
                PH_SYNC_B: begin
                    if (b == SYNC_B) begin
                        phase_next = PH_TYPE;
                    end else if (b != SYNC_A) begin
                        phase_next = PH_SYNC_A;
                    end
                end
                PH_TYPE: begin
                    type_next  = b;
                    crc_next   = crc8_add(8'd0, b);
                    phase_next = PH_SEQ;
                end
                PH_SEQ: begin
                    seq_next   = b;
                    crc_next   = crc8_add(crc_reg, b);
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (b > MAX_PAYLOAD) begin
                        phase_next = PH_SYNC_A;
                    end else begin
                        len_next   = b[LEN_W-1:0];
                        crc_next   = crc8_add(crc_reg, b);
                        fill_next  = '0;
                        phase_next = (b == 8'd0) ? PH_CHECK : PH_BODY;
                    end
                end
                PH_BODY: begin
                    head_we   = (fill_reg < LEN_W'(HEAD_BYTES));
                    fill_next = fill_inc;
                    crc_next  = crc8_add(crc_reg, b);
                    if (fill_inc >= len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    evt_fire   = 1'b1;
                    evt_crc_ok = (b == crc_reg);
                    phase_next = PH_SYNC_A;
                end
                default: begin
                    phase_next = (b == SYNC_A) ? PH_SYNC_B : PH_SYNC_A;
                end
            endcase
        end
    end

    // frame fields seen by the tracker
    assign evt = {evt_fire, evt_crc_ok, type_reg, seq_reg, len_reg, head_reg, item.now_us};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC_A;
            type_reg  <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            fill_reg  <= '0;
            crc_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            crc_reg   <= crc_next;
        end
    end

    // first payload bytes, the only ones a control frame decodes
    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_reg[fill_reg[HEAD_IDX_W-1:0]] <= b;
        end
    end

endmodule

`default_nettype wire

>>> hdl/cfr_frame_tracker.sv
// per-type sequence tracking, imu gap timing and control decode
// depends on cfr_pkg
`default_nettype none

module cfr_frame_tracker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire cfr_pkg::frame_evt_t evt,
    output cfr_pkg::result_t        res
);
    import cfr_pkg::*;

    logic [7:0]           last_seq_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] seen_reg, seen_next;
    logic [31:0]          last_imu_reg, last_imu_next;
    logic                 imu_valid_reg, imu_valid_next;
    logic [15:0]          flags_reg, flags_next;
    logic [15:0]          rate_reg, rate_next;
    logic [3:0]           div_reg, div_next;
    logic [15:0]          timeout_reg, timeout_next;
    logic [7:0]           session_reg, session_next;
    logic                 active_reg, active_next;
    logic [31:0]          late_gap_reg;

    logic [2:0]  slot;
    logic        known;
    logic        good;
    logic        seq_we;
    logic [7:0]  delta;
    logic [31:0] gap;
    logic        ctl_ok;
    logic [15:0] dec_flags;
    logic [15:0] dec_timeout;
    logic [3:0]  dec_div;

    // type to tracking slot
    always_comb begin
        known = 1'b1;
        slot  = 3'd0;
        if (evt.kind >= KIND_IMU && evt.kind <= KIND_LAST_PLAIN) begin
            slot = evt.kind[2:0] - 3'd1;
        end else if (evt.kind == KIND_CONTROL) begin
            slot = CONTROL_SLOT;
        end else begin
            known = 1'b0;
        end
    end

    assign good  = evt.fire && known && evt.crc_ok;
    assign delta = evt.seq - last_seq_reg[slot];
    assign gap   = evt.now_us - last_imu_reg;

    // control payload decode
    assign ctl_ok      = (evt.length >= LEN_W'(CONTROL_MIN_LEN))
                         && (evt.head[0] == CONTROL_VERSION);
    assign dec_flags   = {evt.head[2], evt.head[1]};
    assign dec_timeout = ({evt.head[7], evt.head[6]} == 16'd0) ? DEFAULT_TIMEOUT
                                                               : {evt.head[7], evt.head[6]};
    always_comb begin
        if (evt.head[5] == 8'd0) begin
            dec_div = 4'd1;
        end else if (evt.head[5] > MAX_DIVISOR) begin
            dec_div = MAX_DIVISOR[3:0];
        end else begin
            dec_div = evt.head[5][3:0];
        end
    end

    // frame completion: state update and result
    always_comb begin
        seen_next      = seen_reg;
        last_imu_next  = last_imu_reg;
        imu_valid_next = imu_valid_reg;
        flags_next     = flags_reg;
        rate_next      = rate_reg;
        div_next       = div_reg;
        timeout_next   = timeout_reg;
        session_next   = session_reg;
        active_next    = active_reg;
        seq_we         = 1'b0;

        res.frame_status = STATUS_DELIVERED;
        res.lost_frames  = 8'd0;
        res.imu_gap_us   = 32'd0;
        res.imu_gap_kind = GAP_NONE;

        if (!known) begin
            res.frame_status = STATUS_UNKNOWN;
        end else if (!evt.crc_ok) begin
            res.frame_status = STATUS_CRC_ERR;
        end

        if (good) begin
            if (seen_reg[slot] && delta != 8'd1) begin
                res.lost_frames = delta - 8'd1;
            end
            seq_we          = 1'b1;
            seen_next[slot] = 1'b1;

            if (evt.kind == KIND_IMU) begin
                if (imu_valid_reg) begin
                    res.imu_gap_us   = gap;
                    res.imu_gap_kind = (gap > late_gap_reg) ? GAP_LATE : GAP_OK;
                end
                last_imu_next  = evt.now_us;
                imu_valid_next = 1'b1;
            end else if (evt.kind == KIND_CONTROL) begin
                if (!ctl_ok) begin
                    res.frame_status = STATUS_BAD_CTRL;
                end else begin
                    // enable edge starts a new session
                    if (dec_flags[0] && !active_reg) begin
                        session_next   = session_reg + 8'd1;
                        seen_next      = '0;
                        seen_next[CONTROL_SLOT] = 1'b1;
                        imu_valid_next = 1'b0;
                        last_imu_next  = evt.now_us;
                    end
                    flags_next   = dec_flags;
                    rate_next    = {evt.head[4], evt.head[3]};
                    div_next     = dec_div;
                    timeout_next = dec_timeout;
                    active_next  = dec_flags[0];
                end
            end
        end

        res.frame_kind     = evt.kind;
        res.frame_number   = evt.seq;
        res.stream_enabled = active_next;
        res.session_number = session_next;
        res.control_flags  = flags_next;
        res.imu_rate_hz    = rate_next;
        res.return_divisor = div_next;
        res.timeout_ms     = timeout_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            last_imu_reg  <= '0;
            imu_valid_reg <= 1'b0;
            flags_reg     <= '0;
            rate_reg      <= '0;
            div_reg       <= '0;
            timeout_reg   <= '0;
            session_reg   <= '0;
            active_reg    <= 1'b0;
        end else begin
            seen_reg      <= seen_next;
            last_imu_reg  <= last_imu_next;
            imu_valid_reg <= imu_valid_next;
            flags_reg     <= flags_next;
            rate_reg      <= rate_next;
            div_reg       <= div_next;
            timeout_reg   <= timeout_next;
            session_reg   <= session_next;
            active_reg    <= active_next;
        end
    end

    // last sequence per slot, meaningful only where the seen bit is set
    always_ff @(posedge aclk) begin
        if (seq_we) begin
            last_seq_reg[slot] <= evt.seq;
        end
    end

    // late gap threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            late_gap_reg <= LATE_GAP_RESET;
        end else if (cfg_wr_en) begin
            late_gap_reg <= cfg_wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/crc8_frame_receiver_unit.sv
// Framed byte stream receiver with crc-8/dvb-s2 check, top level.
// Depends on cfr_pkg, cfr_input_stage, cfr_frame_parser, cfr_frame_tracker.
//
// Usage:
//   s_ channel carries one received byte per transfer with its microsecond
//   arrival time. Frames are A5 5A, type, sequence, length, payload, crc.
//   m_ channel carries one result per completed frame (on its crc byte),
//   nothing for any other byte. cfg_wr_en/cfg_wr_data set the late gap limit.
// A result enters the result register when the parser takes its crc byte.
// Throughput: 1 byte per cycle while s_tready is high; each byte passes the input
//   register and one parser/tracker update before the result register.
// Reset (aresetn low, synchronous): parser hunts for A5, tracking, imu
//   timing and control state clear, late gap limit 5000, m_tvalid low.
// Stall: while a result waits on m_tready the block keeps taking bytes; only
//   a further crc byte is held in the input register, which then drops
//   s_tready until the waiting result is transferred.
`default_nettype none

module crc8_frame_receiver_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config: late gap limit in microseconds
    input  wire logic                            cfg_wr_en,
    input  wire logic [31:0]                     cfg_wr_data,
    // byte input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: rx_byte [7:0], now_us [39:8]
    input  wire logic [cfr_pkg::S_TDATA_W-1:0]   s_tdata,
    // frame results
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: frame_status [1:0], frame_number [9:2], lost_frames [17:10],
    //   imu_gap_us [49:18], imu_gap_kind [51:50], stream_enabled [52],
    //   session_number [60:53], control_flags [76:61], imu_rate_hz [92:77],
    //   return_divisor [96:93], timeout_ms [112:97], zero [119:113]
    output logic [cfr_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: frame_kind [7:0]
    output logic [cfr_pkg::M_TUSER_W-1:0]        m_tuser
);
    import cfr_pkg::*;

    logic       item_valid;
    in_item_t   item;
    logic       take;
    logic       out_busy;
    frame_evt_t evt;
    result_t    res;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    assign out_busy = m_valid_reg && !m_tready;

    cfr_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    cfr_frame_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_busy   (out_busy),
        .take       (take),
        .evt        (evt)
    );

    cfr_frame_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .evt         (evt),
        .res         (res)
    );

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (evt.fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (evt.fire) begin
            m_user_reg <= res.frame_kind;
            m_data_reg <= {7'd0, res.timeout_ms, res.return_divisor, res.imu_rate_hz,
                           res.control_flags, res.session_number, res.stream_enabled,
                           res.imu_gap_kind, res.imu_gap_us, res.lost_frames,
                           res.frame_number, res.frame_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

>>> hdl/cfr_checker.sv
// port-level assertions of the frame receiver and their bind
// depends on cfr_pkg, assert_macros.svh, crc8_frame_receiver_unit
`default_nettype none
`include "assert_macros.svh"

module cfr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cfr_pkg::M_TDATA_W-1:0] m_tdata
);
    import cfr_pkg::*;

    // result held while the receiver stalls
    `CFR_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // no result right after reset
    `CFR_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid)

    // an unmeasured gap reads as zero
    `CFR_ASSERT(a_gap_zero, aclk, aresetn, m_tvalid && (m_tdata[51:50] == GAP_NONE) |-> (m_tdata[49:18] == 32'd0))

    // failed frames report no loss and no gap
    `CFR_ASSERT(a_fail_clean, aclk, aresetn, m_tvalid && (m_tdata[1:0] == STATUS_CRC_ERR || m_tdata[1:0] == STATUS_UNKNOWN) |-> (m_tdata[17:10] == 8'd0) && (m_tdata[51:50] == GAP_NONE))

    // divisor and timeout are both unset or both set
    `CFR_ASSERT(a_ctl_pair, aclk, aresetn, m_tvalid |-> ((m_tdata[96:93] == 4'd0) == (m_tdata[112:97] == 16'd0)))

endmodule

bind crc8_frame_receiver_unit cfr_checker u_cfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
